// ----- sv/rcfr_pkg.sv -----
// ----------------------------------------------------------------------------
// rcfr_pkg: shared types and decode functions for the rc frame receiver
// frame lengths, header codes, result layout and bit unpacking of frames
// ----------------------------------------------------------------------------
package rcfr_pkg;

  localparam int unsigned CH_W       = 11;
  localparam int unsigned NUM_CH     = 8;
  localparam int unsigned DBUS_LEN   = 18;
  localparam int unsigned SBUS_LEN   = 25;
  localparam logic [7:0]  SBUS_HEAD  = 8'h0F;
  localparam logic [7:0]  SBUS_TAIL  = 8'h00;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_DBUS = 2'd1,
    KIND_SBUS = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAP_MS          = 4'd0,
    CFG_LINK_TIMEOUT_MS = 4'd1
  } cfg_idx_t;

  typedef logic [NUM_CH-1:0][CH_W-1:0] chan_arr_t;

  // one result transaction
  typedef struct packed {
    kind_t       kind;
    chan_arr_t   chans;
    logic [1:0]  sw_left;
    logic [1:0]  sw_right;
    logic        link;
  } result_t;

  // bytes of a frame in arrival order, index 0 first
  typedef logic [11:0][7:0] frame_win_t;

  typedef struct packed {
    chan_arr_t  chans;
    logic [1:0] sw_left;
    logic [1:0] sw_right;
  } decode_t;

  // dbus: four channels from bytes 0..5, switches in byte 5
  function automatic decode_t decode_dbus(input frame_win_t b);
    logic [15:0] w01;
    logic [15:0] w12;
    logic [23:0] w234;
    logic [15:0] w45;
    decode_t     d;
    w01  = {b[1], b[0]};
    w12  = {b[2], b[1]};
    w234 = {b[4], b[3], b[2]};
    w45  = {b[5], b[4]};
    d          = '0;
    d.chans[0] = w01[10:0];
    d.chans[1] = w12[13:3];
    d.chans[2] = w234[16:6];
    d.chans[3] = w45[11:1];
    d.sw_left  = b[5][5:4];
    d.sw_right = b[5][7:6];
    return d;
  endfunction

  // sbus: eight channels packed lsb first from byte 1 on
  function automatic chan_arr_t decode_sbus(input frame_win_t b);
    logic [15:0] w12;
    logic [15:0] w23;
    logic [23:0] w345;
    logic [15:0] w56;
    logic [15:0] w67;
    logic [23:0] w789;
    logic [15:0] w910;
    logic [15:0] w1011;
    chan_arr_t   c;
    w12   = {b[2], b[1]};
    w23   = {b[3], b[2]};
    w345  = {b[5], b[4], b[3]};
    w56   = {b[6], b[5]};
    w67   = {b[7], b[6]};
    w789  = {b[9], b[8], b[7]};
    w910  = {b[10], b[9]};
    w1011 = {b[11], b[10]};
    c[0] = w12[10:0];
    c[1] = w23[13:3];
    c[2] = w345[16:6];
    c[3] = w56[11:1];
    c[4] = w67[14:4];
    c[5] = w789[17:7];
    c[6] = w910[12:2];
    c[7] = w1011[15:5];
    return c;
  endfunction

endpackage

// ----- sv/rc_frame_receiver_unit.sv -----
// ----------------------------------------------------------------------------
// rc_frame_receiver_unit: remote-control frame decoder (dbus / sbus)
//
// input channel (in_valid / in_stall): cmd 0 carries a received uart byte in
// rx_byte, cmd 1 is a one millisecond tick. every accepted transaction makes
// exactly one result transaction on the output channel (out_valid /
// out_stall) with the frame kind just completed and the held channel,
// switch and link values after that item.
// throughput: one item per cycle while in_stall is low. the result of an
// accepted item is registered in the output buffer; all per-item work is one
// pass through the counters and the decode of fixed taps of the byte chain.
// a two-entry output buffer decouples the sides: in_stall rises only when a
// result is held and a second one waits behind it while out_stall is high.
// config (cfg_valid / cfg_ready, cfg_index, cfg_data) is always ready and
// must be written only while the block is idle.
// reset (rst, synchronous) clears counters, link flag, channel and switch
// stores, empties the output buffer and loads gap_ms 2 and timeout 100.
// the frame byte chain is not reset; a decode only reads bytes of the
// current frame.
// ----------------------------------------------------------------------------
module rc_frame_receiver_unit #(
  parameter int unsigned FRAME_DEPTH = 25
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // item input
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  cmd,
  input  logic [7:0]                            rx_byte,
  // result output
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [1:0]                            frame_kind,
  output logic [rcfr_pkg::CH_W-1:0]             channel_0,
  output logic [rcfr_pkg::CH_W-1:0]             channel_1,
  output logic [rcfr_pkg::CH_W-1:0]             channel_2,
  output logic [rcfr_pkg::CH_W-1:0]             channel_3,
  output logic [rcfr_pkg::CH_W-1:0]             channel_4,
  output logic [rcfr_pkg::CH_W-1:0]             channel_5,
  output logic [rcfr_pkg::CH_W-1:0]             channel_6,
  output logic [rcfr_pkg::CH_W-1:0]             channel_7,
  output logic [1:0]                            switch_left,
  output logic [1:0]                            switch_right,
  output logic                                  link_up,
  // config write
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [rcfr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rcfr_pkg::CFG_DATA_W-1:0]       cfg_data
);

  // the last byte of a frame never needs storing, it is decoded on arrival
  localparam int unsigned NCELL   = FRAME_DEPTH - 1;
  localparam int unsigned CNT_W   = $clog2(FRAME_DEPTH);
  localparam int unsigned CNTP_W  = CNT_W + 1;
  // chain taps: byte i of a frame sits in cell (len - 2 - i) on arrival of
  // the frame's last byte
  localparam int unsigned DBUS_TOP = rcfr_pkg::DBUS_LEN - 2;
  localparam int unsigned SBUS_TOP = rcfr_pkg::SBUS_LEN - 2;

  // configuration
  logic [7:0]  gap_ms;
  logic [15:0] link_timeout_ms;

  // control state
  logic [CNT_W-1:0] byte_count;
  logic [CNT_W-1:0] byte_count_next;
  logic [7:0]       ms_since_byte;
  logic [7:0]       ms_since_byte_next;
  logic [15:0]      ms_since_frame;
  logic [15:0]      ms_since_frame_next;
  logic             link_flag;
  logic             link_flag_next;
  rcfr_pkg::chan_arr_t channel_store;
  rcfr_pkg::chan_arr_t channel_store_next;
  logic [1:0]       sw_left;
  logic [1:0]       sw_left_next;
  logic [1:0]       sw_right;
  logic [1:0]       sw_right_next;

  logic              accept;
  logic              shift;
  logic [CNT_W-1:0]  cnt_eff;
  logic [CNTP_W-1:0] cnt_new;
  rcfr_pkg::kind_t   kind;
  rcfr_pkg::frame_win_t dbus_win;
  rcfr_pkg::frame_win_t sbus_win;
  rcfr_pkg::decode_t    dbus_dec;
  rcfr_pkg::result_t    res;
  rcfr_pkg::result_t    out_res;
  logic [7:0]           sbus_first;
  logic                 buf_full;

  logic [7:0] cell_q [NCELL];

  assign accept    = in_valid && !in_stall;
  assign in_stall  = buf_full;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------------------
  // config registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_ms          <= 8'd2;
      link_timeout_ms <= 16'd100;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rcfr_pkg::CFG_GAP_MS:          gap_ms          <= cfg_data[7:0];
        rcfr_pkg::CFG_LINK_TIMEOUT_MS: link_timeout_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // byte chain: cell 0 takes the incoming byte, every cell passes its byte on
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    if (k == 0) begin : g_head
      rcfr_byte_cell u_cell (
        .clk  (clk),
        .shift(shift),
        .din  (rx_byte),
        .dout (cell_q[k])
      );
    end else begin : g_link
      rcfr_byte_cell u_cell (
        .clk  (clk),
        .shift(shift),
        .din  (cell_q[k-1]),
        .dout (cell_q[k])
      );
    end
  end

  // fixed taps into the chain for both frame formats
  always_comb begin
    dbus_win = '0;
    sbus_win = '0;
    for (int i = 0; i < 6; i++) begin
      dbus_win[i] = cell_q[DBUS_TOP - i];
    end
    for (int i = 1; i < 12; i++) begin
      sbus_win[i] = cell_q[SBUS_TOP - i];
    end
  end

  assign sbus_first = cell_q[SBUS_TOP];
  assign dbus_dec   = rcfr_pkg::decode_dbus(dbus_win);

  // ---------------------------------------------------------------------------
  // per-item update
  // ---------------------------------------------------------------------------
  always_comb begin
    byte_count_next     = byte_count;
    ms_since_byte_next  = ms_since_byte;
    ms_since_frame_next = ms_since_frame;
    link_flag_next      = link_flag;
    channel_store_next  = channel_store;
    sw_left_next        = sw_left;
    sw_right_next       = sw_right;
    kind                = rcfr_pkg::KIND_NONE;
    shift               = 1'b0;
    cnt_eff             = byte_count;
    cnt_new             = CNTP_W'(byte_count) + 1'b1;

    if (accept) begin
      if (cmd) begin
        // millisecond tick
        if (ms_since_frame >= link_timeout_ms) begin
          link_flag_next = 1'b0;
        end
        if (ms_since_byte != 8'hFF) begin
          ms_since_byte_next = ms_since_byte + 8'd1;
        end
        if (ms_since_frame != 16'hFFFF) begin
          ms_since_frame_next = ms_since_frame + 16'd1;
        end
      end else begin
        // received byte; a long gap drops the partial frame
        if (byte_count != '0 && ms_since_byte >= gap_ms) begin
          cnt_eff = '0;
        end
        cnt_new            = CNTP_W'(cnt_eff) + 1'b1;
        ms_since_byte_next = '0;
        if (CNTP_W'(cnt_eff) >= CNTP_W'(FRAME_DEPTH)) begin
          byte_count_next = '0;
        end else begin
          shift           = 1'b1;
          byte_count_next = cnt_new[CNT_W-1:0];
          if (cnt_new == CNTP_W'(rcfr_pkg::DBUS_LEN)) begin
            channel_store_next[3:0] = dbus_dec.chans[3:0];
            sw_left_next            = dbus_dec.sw_left;
            sw_right_next           = dbus_dec.sw_right;
            link_flag_next          = 1'b1;
            ms_since_frame_next     = '0;
            kind                    = rcfr_pkg::KIND_DBUS;
            byte_count_next         = '0;
          end else if (cnt_new == CNTP_W'(rcfr_pkg::SBUS_LEN)) begin
            // last byte is the footer, still on the input
            if (sbus_first == rcfr_pkg::SBUS_HEAD && rx_byte == rcfr_pkg::SBUS_TAIL) begin
              channel_store_next  = rcfr_pkg::decode_sbus(sbus_win);
              link_flag_next      = 1'b1;
              ms_since_frame_next = '0;
              kind                = rcfr_pkg::KIND_SBUS;
            end
            byte_count_next = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      ms_since_byte  <= '0;
      ms_since_frame <= '0;
      link_flag      <= 1'b0;
      channel_store  <= '0;
      sw_left        <= '0;
      sw_right       <= '0;
    end else begin
      byte_count     <= byte_count_next;
      ms_since_byte  <= ms_since_byte_next;
      ms_since_frame <= ms_since_frame_next;
      link_flag      <= link_flag_next;
      channel_store  <= channel_store_next;
      sw_left        <= sw_left_next;
      sw_right       <= sw_right_next;
    end
  end

  // result carries the state after this item
  always_comb begin
    res.kind     = kind;
    res.chans    = channel_store_next;
    res.sw_left  = sw_left_next;
    res.sw_right = sw_right_next;
    res.link     = link_flag_next;
  end

  // ---------------------------------------------------------------------------
  // output buffer
  // ---------------------------------------------------------------------------
  rcfr_out_buffer u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_data(res),
    .full     (buf_full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_res)
  );

  assign frame_kind   = out_res.kind;
  assign channel_0    = out_res.chans[0];
  assign channel_1    = out_res.chans[1];
  assign channel_2    = out_res.chans[2];
  assign channel_3    = out_res.chans[3];
  assign channel_4    = out_res.chans[4];
  assign channel_5    = out_res.chans[5];
  assign channel_6    = out_res.chans[6];
  assign channel_7    = out_res.chans[7];
  assign switch_left  = out_res.sw_left;
  assign switch_right = out_res.sw_right;
  assign link_up      = out_res.link;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // a stalled input means a result is waiting at the output
  a_stall_needs_output: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result at the output");

  // a dbus-length count always closes the frame
  a_count_below_dbus: assert property (@(posedge clk) disable iff (rst)
    CNTP_W'(byte_count) < CNTP_W'(rcfr_pkg::DBUS_LEN))
    else $error("byte count ran past the dbus frame length");

  // a decoded frame brings the link up and restarts the frame timer
  a_frame_sets_link: assert property (@(posedge clk) disable iff (rst)
    (accept && kind != rcfr_pkg::KIND_NONE) |=> (link_flag && ms_since_frame == '0))
    else $error("decoded frame did not raise the link");

  // ticks never touch the byte count
  a_tick_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd) |=> $stable(byte_count))
    else $error("tick changed the byte count");

endmodule

// ----- sv/rcfr_byte_cell.sv -----
// ----------------------------------------------------------------------------
// rcfr_byte_cell: one byte cell of the frame shift chain
// takes its neighbor's byte whenever a received byte moves the chain
// ----------------------------------------------------------------------------
module rcfr_byte_cell (
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] din,
  output logic [7:0] dout
);

  logic [7:0] data;

  // payload only, no reset
  always_ff @(posedge clk) begin
    if (shift) begin
      data <= din;
    end
  end

  assign dout = data;

endmodule

// ----- sv/rcfr_out_buffer.sv -----
// ----------------------------------------------------------------------------
// rcfr_out_buffer: two-entry output skid buffer
// output register plus a spare slot so in_stall comes from a register only
// ----------------------------------------------------------------------------
module rcfr_out_buffer (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rcfr_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output rcfr_pkg::result_t out_data
);

  logic              main_valid;
  logic              spare_valid;
  rcfr_pkg::result_t main_data;
  rcfr_pkg::result_t spare_data;
  logic              take;

  assign take = main_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid  <= 1'b0;
      spare_valid <= 1'b0;
    end else if (spare_valid) begin
      if (take) begin
        main_valid  <= 1'b1;
        spare_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid || take) begin
        main_valid <= 1'b1;
      end else begin
        spare_valid <= 1'b1;
      end
    end else if (take) begin
      main_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (spare_valid) begin
      if (take) begin
        main_data <= spare_data;
      end
    end else if (push) begin
      if (!main_valid || take) begin
        main_data <= push_data;
      end else begin
        spare_data <= push_data;
      end
    end
  end

  assign full      = spare_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

endmodule

// ----- verif/tb_rc_frame_receiver_unit.sv -----
// ----------------------------------------------------------------------------
// tb_rc_frame_receiver_unit: self-checking bench for the rc frame receiver
// drives uart bytes and millisecond ticks through the valid/stall input
// channel, predicts every result transaction with a behavioral decoder
// model (frame gathering, gap restart, dbus/sbus unpacking, link timeout)
// and compares each output field; directed corner tests run first, then
// random frame traffic over several register settings
// ----------------------------------------------------------------------------
module tb_rc_frame_receiver_unit;

  localparam int unsigned GAP_RESET_MS     = 2;
  localparam int unsigned TIMEOUT_RESET_MS = 100;
  localparam int unsigned IDLE_SAT_MS      = 255;
  localparam int unsigned SETTLE_CYCLES    = 8;
  localparam int unsigned DRAIN_LIMIT      = 5000;
  localparam int unsigned HOLD_CYCLES      = 64;
  // index that maps to no register, writes to it must be ignored
  localparam logic [rcfr_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 4'hF;

  logic                            clk;
  logic                            rst;
  logic                            in_valid;
  logic                            in_stall;
  logic                            cmd;
  logic [7:0]                      rx_byte;
  logic                            out_valid;
  logic                            out_stall;
  logic [1:0]                      frame_kind;
  logic [rcfr_pkg::CH_W-1:0]       channel_0;
  logic [rcfr_pkg::CH_W-1:0]       channel_1;
  logic [rcfr_pkg::CH_W-1:0]       channel_2;
  logic [rcfr_pkg::CH_W-1:0]       channel_3;
  logic [rcfr_pkg::CH_W-1:0]       channel_4;
  logic [rcfr_pkg::CH_W-1:0]       channel_5;
  logic [rcfr_pkg::CH_W-1:0]       channel_6;
  logic [rcfr_pkg::CH_W-1:0]       channel_7;
  logic [1:0]                      switch_left;
  logic [1:0]                      switch_right;
  logic                            link_up;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [rcfr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rcfr_pkg::CFG_DATA_W-1:0] cfg_data;

  // idling controls shared by the driver and the receiver process
  bit          sender_idle_en;
  bit          receiver_idle_en;
  bit          hold_request;
  int unsigned hold_len;
  int unsigned items_sent;
  int unsigned fail_count;

  // decoder model state
  logic [7:0]                held_bytes [rcfr_pkg::SBUS_LEN];
  int unsigned               bytes_in_frame;
  int unsigned               ms_idle;
  int unsigned               ms_no_frame;
  logic                      link_seen;
  logic [rcfr_pkg::CH_W-1:0] chan_hold [rcfr_pkg::NUM_CH];
  logic [1:0]                sw_left_hold;
  logic [1:0]                sw_right_hold;
  int unsigned               gap_setting;
  int unsigned               timeout_setting;
  rcfr_pkg::result_t         pending_results [$];

  rc_frame_receiver_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_kind   (frame_kind),
    .channel_0    (channel_0),
    .channel_1    (channel_1),
    .channel_2    (channel_2),
    .channel_3    (channel_3),
    .channel_4    (channel_4),
    .channel_5    (channel_5),
    .channel_6    (channel_6),
    .channel_7    (channel_7),
    .switch_left  (switch_left),
    .switch_right (switch_right),
    .link_up      (link_up),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // decoder model
  // ---------------------------------------------------------------------------

  function automatic void reset_decoder_model();
    for (int i = 0; i < rcfr_pkg::SBUS_LEN; i++) held_bytes[i] = 8'h00;
    for (int i = 0; i < rcfr_pkg::NUM_CH; i++) chan_hold[i] = '0;
    bytes_in_frame  = 0;
    ms_idle         = 0;
    ms_no_frame     = 0;
    link_seen       = 1'b0;
    sw_left_hold    = 2'b00;
    sw_right_hold   = 2'b00;
    gap_setting     = GAP_RESET_MS;
    timeout_setting = TIMEOUT_RESET_MS;
  endfunction

  // advance the model by one accepted item and queue the result it yields
  function automatic void step_decoder(input logic is_tick, input logic [7:0] data);
    logic [95:0]       bits;
    rcfr_pkg::kind_t   kind;
    rcfr_pkg::result_t res;
    kind = rcfr_pkg::KIND_NONE;
    if (is_tick) begin
      // link falls once the elapsed time would exceed the timeout
      if (ms_no_frame >= timeout_setting) link_seen = 1'b0;
      if (ms_idle < IDLE_SAT_MS) ms_idle++;
      if (ms_no_frame < 65535) ms_no_frame++;
    end else begin
      // a late byte drops the partial frame, an empty frame is left alone
      if (bytes_in_frame > 0 && ms_idle >= gap_setting) bytes_in_frame = 0;
      ms_idle = 0;
      if (bytes_in_frame >= rcfr_pkg::SBUS_LEN) begin
        bytes_in_frame = 0;
      end else begin
        held_bytes[bytes_in_frame] = data;
        bytes_in_frame++;
        // frame bytes little endian, channels are 11-bit fields of this vector
        for (int i = 0; i < 12; i++) bits[8*i +: 8] = held_bytes[i];
        if (bytes_in_frame == rcfr_pkg::DBUS_LEN) begin
          for (int i = 0; i < 4; i++) chan_hold[i] = bits[11*i +: 11];
          sw_left_hold  = held_bytes[5][5:4];
          sw_right_hold = held_bytes[5][7:6];
          link_seen      = 1'b1;
          ms_no_frame    = 0;
          kind           = rcfr_pkg::KIND_DBUS;
          bytes_in_frame = 0;
        end else if (bytes_in_frame == rcfr_pkg::SBUS_LEN) begin
          if (held_bytes[0] == rcfr_pkg::SBUS_HEAD &&
              held_bytes[rcfr_pkg::SBUS_LEN-1] == rcfr_pkg::SBUS_TAIL) begin
            // sbus data starts at frame byte 1
            for (int i = 0; i < rcfr_pkg::NUM_CH; i++) begin
              chan_hold[i] = bits[8 + 11*i +: 11];
            end
            link_seen   = 1'b1;
            ms_no_frame = 0;
            kind        = rcfr_pkg::KIND_SBUS;
          end
          bytes_in_frame = 0;
        end
      end
    end
    res.kind = kind;
    for (int i = 0; i < rcfr_pkg::NUM_CH; i++) res.chans[i] = chan_hold[i];
    res.sw_left  = sw_left_hold;
    res.sw_right = sw_right_hold;
    res.link     = link_seen;
    pending_results.push_back(res);
  endfunction

  // ---------------------------------------------------------------------------
  // drivers, all entered and left at a falling edge
  // ---------------------------------------------------------------------------

  // one input transaction, the model advances at the accepting edge
  task automatic send_rc_item(input logic is_tick, input logic [7:0] data);
    if (sender_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= is_tick;
    rx_byte  <= data;
    do @(posedge clk); while (in_stall);
    step_decoder(is_tick, data);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_rc_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  // byte values lean toward the field extremes and the sbus header
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return rcfr_pkg::SBUS_HEAD;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random_bytes(input int unsigned n);
    repeat (n) send_rc_item(1'b0, pick_byte());
  endtask

  // alternating two values, a single value when both are the same
  task automatic send_pattern(input logic [7:0] a, input logic [7:0] b,
                              input int unsigned n);
    for (int i = 0; i < n; i++) send_rc_item(1'b0, (i % 2 == 0) ? a : b);
  endtask

  // only called while the block is idle
  task automatic write_register(input logic [rcfr_pkg::CFG_IDX_W-1:0] idx,
                                input logic [rcfr_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == rcfr_pkg::CFG_GAP_MS) gap_setting = value[7:0];
    else if (idx == rcfr_pkg::CFG_LINK_TIMEOUT_MS) timeout_setting = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // stop offering, wait for every predicted result, then let the pipe settle
  task automatic drain_results();
    int unsigned guard;
    in_valid <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_idling(input bit on);
    sender_idle_en   = on;
    receiver_idle_en = on;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // default registers right after reset, stores must read zero
  task automatic test_reset_state();
    set_idling(1'b1);
    send_ticks(3);
    send_pattern(8'h00, 8'h00, 2);
    drain_results();
  endtask

  // extreme register values, extreme byte values, writes that must be ignored
  task automatic test_dbus_extremes();
    // upper data bits of the gap write are dropped by the 8-bit register
    write_register(rcfr_pkg::CFG_GAP_MS, {8'($urandom_range(1, 255)), 8'hFF});
    write_register(rcfr_pkg::CFG_LINK_TIMEOUT_MS, 16'hFFFF);
    write_register(CFG_IDX_UNUSED, 16'hFFFF);
    // channels 0 to 3 at 2047, both switches 3
    send_pattern(8'hFF, 8'hFF, rcfr_pkg::DBUS_LEN);
    // channels and switches back to zero
    send_pattern(8'h00, 8'h00, rcfr_pkg::DBUS_LEN);
    send_pattern(8'h55, 8'hAA, rcfr_pkg::DBUS_LEN);
    send_pattern(8'hAA, 8'h55, rcfr_pkg::DBUS_LEN);
    drain_results();
  endtask

  task automatic test_gap_rules();
    // smallest nonzero gap: a single tick between bytes drops the partial frame
    write_register(rcfr_pkg::CFG_GAP_MS, 16'd1);
    send_random_bytes(5);
    send_ticks(1);
    send_random_bytes(rcfr_pkg::DBUS_LEN);
    drain_results();
    // gap of zero: every byte restarts, nothing ever completes
    write_register(rcfr_pkg::CFG_GAP_MS, 16'd0);
    send_random_bytes(rcfr_pkg::DBUS_LEN + 4);
    drain_results();
    // largest gap: 254 idle ticks keep the frame, a saturated count drops it
    write_register(rcfr_pkg::CFG_GAP_MS, 16'd255);
    send_random_bytes(3);
    send_ticks(IDLE_SAT_MS - 1);
    send_random_bytes(rcfr_pkg::DBUS_LEN - 3);
    send_random_bytes(2);
    send_ticks(IDLE_SAT_MS + 40);
    send_random_bytes(rcfr_pkg::DBUS_LEN);
    drain_results();
    // long silence with no partial frame must not drop anything
    write_register(rcfr_pkg::CFG_GAP_MS, 16'd2);
    send_ticks(10);
    send_random_bytes(rcfr_pkg::DBUS_LEN);
    drain_results();
  endtask

  task automatic test_link_timeout();
    // zero timeout: link drops at the first tick after a frame
    write_register(rcfr_pkg::CFG_LINK_TIMEOUT_MS, 16'd0);
    send_random_bytes(rcfr_pkg::DBUS_LEN);
    send_ticks(2);
    drain_results();
    // timeout of one: link survives one tick, drops on the second
    write_register(rcfr_pkg::CFG_LINK_TIMEOUT_MS, 16'd1);
    send_random_bytes(rcfr_pkg::DBUS_LEN);
    send_ticks(3);
    drain_results();
    // full-scale timeout keeps the link up through a long silence
    write_register(rcfr_pkg::CFG_LINK_TIMEOUT_MS, 16'hFFFF);
    send_random_bytes(rcfr_pkg::DBUS_LEN);
    send_ticks(40);
    drain_results();
  endtask

  // sbus shaped streams: the dbus length always ends the frame first
  task automatic test_sbus_streams();
    write_register(rcfr_pkg::CFG_GAP_MS, 16'd3);
    write_register(rcfr_pkg::CFG_LINK_TIMEOUT_MS, 16'd20);
    send_rc_item(1'b0, rcfr_pkg::SBUS_HEAD);
    send_random_bytes(rcfr_pkg::SBUS_LEN - 2);
    send_rc_item(1'b0, rcfr_pkg::SBUS_TAIL);
    send_ticks(3);
    // bad header and footer
    send_rc_item(1'b0, 8'h00);
    send_random_bytes(rcfr_pkg::SBUS_LEN - 2);
    send_rc_item(1'b0, 8'hFF);
    send_ticks(4);
    drain_results();
  endtask

  // receiver holds off for a long stretch while items keep coming
  task automatic test_backpressure();
    sender_idle_en   = 1'b0;
    receiver_idle_en = 1'b0;
    hold_len = HOLD_CYCLES;
    @(posedge clk);
    hold_request = 1'b1;
    @(negedge clk);
    for (int i = 0; i < 40; i++) begin
      if ($urandom_range(0, 5) == 0) send_ticks(1);
      else send_random_bytes(1);
    end
    drain_results();
    set_idling(1'b1);
  endtask

  // one register setting, mostly well-formed frames with random content
  task automatic run_traffic_phase(input int unsigned gap, input int unsigned timeout,
                                   input int unsigned n_items, input bit idling);
    int unsigned start;
    int unsigned room;
    write_register(rcfr_pkg::CFG_GAP_MS, 16'(gap));
    write_register(rcfr_pkg::CFG_LINK_TIMEOUT_MS, 16'(timeout));
    set_idling(idling);
    start = items_sent;
    // ticks that fit inside a frame without tripping the gap rule
    room = (gap > 1) ? ((gap - 1 > 6) ? 6 : gap - 1) : 0;
    while (items_sent - start < n_items) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          for (int k = 0; k < rcfr_pkg::DBUS_LEN; k++) begin
            if (room > 0 && $urandom_range(0, 7) == 0) send_ticks($urandom_range(1, room));
            send_rc_item(1'b0, pick_byte());
          end
        end
        6: begin
          // broken frame cut off by a long enough silence
          send_random_bytes($urandom_range(1, rcfr_pkg::DBUS_LEN - 1));
          send_ticks(gap + $urandom_range(0, 2));
        end
        7: send_ticks($urandom_range(0, (timeout + 2 > 40) ? 40 : timeout + 2));
        8: begin
          repeat ($urandom_range(1, 10)) begin
            send_rc_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
          end
        end
        default: send_random_bytes($urandom_range(1, 8));   // shifts frame alignment
      endcase
    end
    drain_results();
  endtask

  task automatic test_random_traffic();
    run_traffic_phase(GAP_RESET_MS, TIMEOUT_RESET_MS, 120, 1'b1);
    run_traffic_phase(1, 1, 120, 1'b1);
    run_traffic_phase(255, 40, 100, 1'b1);
    run_traffic_phase($urandom_range(3, 20), $urandom_range(2, 30), 120, 1'b1);
    // closing stretch at full rate
    run_traffic_phase($urandom_range(2, 8), $urandom_range(5, 60), 140, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // result checker, one comparison per accepted result transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rcfr_pkg::result_t         want;
    logic [rcfr_pkg::CH_W-1:0] got_ch [rcfr_pkg::NUM_CH];
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing predicted, frame_kind %0d", frame_kind);
        fail_count++;
      end else begin
        want   = pending_results.pop_front();
        got_ch = '{channel_0, channel_1, channel_2, channel_3,
                   channel_4, channel_5, channel_6, channel_7};
        if (frame_kind !== want.kind) begin
          $error("frame_kind expected %0d actual %0d", want.kind, frame_kind);
          fail_count++;
        end
        for (int i = 0; i < rcfr_pkg::NUM_CH; i++) begin
          if (got_ch[i] !== want.chans[i]) begin
            $error("channel_%0d expected %0d actual %0d", i, want.chans[i], got_ch[i]);
            fail_count++;
          end
        end
        if (switch_left !== want.sw_left) begin
          $error("switch_left expected %0d actual %0d", want.sw_left, switch_left);
          fail_count++;
        end
        if (switch_right !== want.sw_right) begin
          $error("switch_right expected %0d actual %0d", want.sw_right, switch_right);
          fail_count++;
        end
        if (link_up !== want.link) begin
          $error("link_up expected %0d actual %0d", want.link, link_up);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stall bursts, or one long counted hold on request
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned hold_left;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        hold_left = hold_len;
        while (hold_left > 0) begin
          @(negedge clk);
          hold_left--;
        end
        out_stall <= 1'b0;
      end else if (receiver_idle_en && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst              = 1'b1;
    in_valid         = 1'b0;
    cmd              = 1'b0;
    rx_byte          = 8'h00;
    cfg_valid        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    sender_idle_en   = 1'b0;
    receiver_idle_en = 1'b0;
    hold_request     = 1'b0;
    hold_len         = 0;
    items_sent       = 0;
    fail_count       = 0;
    reset_decoder_model();
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_state();
    test_dbus_extremes();
    test_gap_rules();
    test_link_timeout();
    test_sbus_streams();
    test_backpressure();
    test_random_traffic();

    drain_results();
    if (pending_results.size() != 0) begin
      $error("%0d predicted results never arrived", pending_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
